FILE: hdl/sme_pkg.sv
package sme_pkg;

    localparam int DATA_STACK_DEPTH   = 64;
    localparam int RETURN_STACK_DEPTH = 32;
    localparam int REG_COUNT          = 8;
    localparam int PIXEL_WIDTH        = 32;
    localparam int PIXEL_HEIGHT       = 32;
    localparam int PIXEL_COUNT        = PIXEL_WIDTH * PIXEL_HEIGHT;

    localparam int DS_AW  = $clog2(DATA_STACK_DEPTH);
    localparam int DS_DW  = $clog2(DATA_STACK_DEPTH + 1);
    localparam int RS_AW  = $clog2(RETURN_STACK_DEPTH);
    localparam int RS_DW  = $clog2(RETURN_STACK_DEPTH + 1);
    localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int PIX_AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

    typedef enum logic [4:0] {
        OP_PUSH  = 5'd0,
        OP_OUT   = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_MUL   = 5'd4,
        OP_DIV   = 5'd5,
        OP_POPR  = 5'd6,
        OP_PUSHR = 5'd7,
        OP_JMP   = 5'd8,
        OP_JB    = 5'd9,
        OP_JBE   = 5'd10,
        OP_JA    = 5'd11,
        OP_JAE   = 5'd12,
        OP_JE    = 5'd13,
        OP_JNE   = 5'd14,
        OP_CALL  = 5'd15,
        OP_RET   = 5'd16,
        OP_SETP  = 5'd17,
        OP_CLRP  = 5'd18
    } opcode_t;

    localparam logic [2:0] FAULT_NONE  = 3'd0;
    localparam logic [2:0] FAULT_UNDER = 3'd1;
    localparam logic [2:0] FAULT_OVER  = 3'd2;
    localparam logic [2:0] FAULT_DIVZ  = 3'd3;
    localparam logic [2:0] FAULT_INDEX = 3'd4;

    typedef struct packed {
        logic [4:0]         opcode;
        logic signed [31:0] argument;
        logic [15:0]        arg_position;
    } sme_in_t;

    typedef struct packed {
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               redirect;
        logic [15:0]        target;
        logic [2:0]         fault;
    } sme_out_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } sme_div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } sme_div_rsp_t;

endpackage

FILE: hdl/stack_machine_execute_unit.sv
// Stack-machine execute unit: one instruction per request, one result per request. The
// top of the data stack is held in a register and the rest in a single-port memory. Every
// instruction but div passes through accept, memory read, execute and result write; div
// adds a wait for the radix-2 divider, which runs 32 iterations, between execute and
// result write. A new request is taken only after the result write of the previous one.
// After reset a clearing pass sweeps all 1024 pixel entries; no request is taken until
// it is done. A result that is not yet taken holds the unit in its result write step,
// which adds the cycles of that stall.
module stack_machine_execute_unit
    import sme_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sme_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sme_out_t m_data
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_OUT
    } state_t;

    logic [31:0] ds_mem [DATA_STACK_DEPTH];
    logic [15:0] rs_mem [RETURN_STACK_DEPTH];
    logic        px_mem [PIXEL_COUNT];

    state_t             state_reg;
    sme_in_t            req_reg;
    logic [DS_DW-1:0]   dd_reg;
    logic [RS_DW-1:0]   rd_reg;
    logic [31:0]        tos_reg;
    logic [31:0]        nos_reg;
    logic [15:0]        rsq_reg;
    logic [31:0]        gr_reg [REG_COUNT];
    logic [PIX_AW-1:0]  clr_reg;
    logic               m_valid_reg;
    sme_out_t           m_data_reg;
    sme_out_t           res_reg;
    sme_div_req_t       dreq;
    sme_div_rsp_t       drsp;

    logic [4:0]        op;
    logic [31:0]       arg;
    logic              arg_idx_bad;
    logic              arg_tgt_bad;
    logic [REG_AW-1:0] ridx;
    logic [31:0]       rval;
    logic              taken;
    logic signed [31:0] ts, ns;

    assign op          = req_reg.opcode;
    assign arg         = req_reg.argument;
    assign arg_idx_bad = arg >= 32'(REG_COUNT);
    assign arg_tgt_bad = arg > 32'hFFFF;
    assign ridx        = arg[REG_AW-1:0];
    assign rval        = gr_reg[ridx];
    assign ts          = tos_reg;
    assign ns          = nos_reg;

    always_comb begin
        case (op)
            OP_JB:   taken = ts > ns;
            OP_JBE:  taken = ts >= ns;
            OP_JA:   taken = ts < ns;
            OP_JAE:  taken = ts <= ns;
            OP_JE:   taken = ts == ns;
            default: taken = ts != ns;
        endcase
    end

    sme_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign dreq.start    = (state_reg == ST_EXEC) && (op == OP_DIV) && (dd_reg >= DS_DW'(2))
                           && (nos_reg != 32'd0);
    assign dreq.dividend = tos_reg;
    assign dreq.divisor  = nos_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // tos lives in tos_reg; memory entry k holds stack position k for k < depth-1
    always_ff @(posedge aclk) begin
        sme_out_t r;
        state_t   nxt;
        r = '0;
        nxt = ST_OUT;
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            dd_reg      <= '0;
            rd_reg      <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) gr_reg[i] <= '0;
        end else begin
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    px_mem[clr_reg] <= 1'b0;
                    clr_reg <= clr_reg + PIX_AW'(1);
                    if (clr_reg == PIX_AW'(PIXEL_COUNT - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (dd_reg >= DS_DW'(2)) nos_reg <= ds_mem[DS_AW'(dd_reg - DS_DW'(2))];
                    if (rd_reg >= RS_DW'(1)) rsq_reg <= rs_mem[RS_AW'(rd_reg - RS_DW'(1))];
                    state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    case (op)
                        OP_PUSH, OP_PUSHR: begin
                            if (op == OP_PUSHR && arg_idx_bad) r.fault = FAULT_INDEX;
                            else if (dd_reg >= DS_DW'(DATA_STACK_DEPTH)) r.fault = FAULT_OVER;
                            else begin
                                if (dd_reg != '0) ds_mem[DS_AW'(dd_reg - DS_DW'(1))] <= tos_reg;
                                tos_reg <= (op == OP_PUSHR) ? rval : arg;
                                dd_reg  <= dd_reg + DS_DW'(1);
                            end
                        end
                        OP_OUT: begin
                            if (dd_reg == '0) r.fault = FAULT_UNDER;
                            else begin
                                r.print_valid = 1'b1;
                                r.print_value = tos_reg;
                                tos_reg <= nos_reg;
                                dd_reg  <= dd_reg - DS_DW'(1);
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (dd_reg < DS_DW'(2)) r.fault = FAULT_UNDER;
                            else if (op == OP_DIV) begin
                                if (nos_reg == 32'd0) r.fault = FAULT_DIVZ;
                                else nxt = ST_DIV;
                            end else begin
                                case (op)
                                    OP_ADD:  tos_reg <= tos_reg + nos_reg;
                                    OP_SUB:  tos_reg <= tos_reg - nos_reg;
                                    default: tos_reg <= tos_reg * nos_reg;
                                endcase
                                dd_reg <= dd_reg - DS_DW'(1);
                            end
                        end
                        OP_POPR: begin
                            if (arg_idx_bad) r.fault = FAULT_INDEX;
                            else if (dd_reg == '0) r.fault = FAULT_UNDER;
                            else begin
                                gr_reg[ridx] <= tos_reg;
                                tos_reg <= nos_reg;
                                dd_reg  <= dd_reg - DS_DW'(1);
                            end
                        end
                        OP_JMP: begin
                            if (arg_tgt_bad) r.fault = FAULT_INDEX;
                            else begin
                                r.redirect = 1'b1;
                                r.target   = arg[15:0];
                            end
                        end
                        OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                            if (arg_tgt_bad) r.fault = FAULT_INDEX;
                            else if (dd_reg < DS_DW'(2)) r.fault = FAULT_UNDER;
                            else begin
                                // new tos is read straight from memory entry depth-3 in this step
                                if (dd_reg >= DS_DW'(3))
                                    tos_reg <= ds_mem[DS_AW'(dd_reg - DS_DW'(3))];
                                dd_reg <= dd_reg - DS_DW'(2);
                                if (taken) begin
                                    r.redirect = 1'b1;
                                    r.target   = arg[15:0];
                                end
                            end
                        end
                        OP_CALL: begin
                            if (arg_tgt_bad) r.fault = FAULT_INDEX;
                            else if (rd_reg >= RS_DW'(RETURN_STACK_DEPTH)) r.fault = FAULT_OVER;
                            else begin
                                rs_mem[RS_AW'(rd_reg)] <= req_reg.arg_position;
                                rd_reg     <= rd_reg + RS_DW'(1);
                                r.redirect = 1'b1;
                                r.target   = arg[15:0];
                            end
                        end
                        OP_RET: begin
                            if (rd_reg == '0) r.fault = FAULT_UNDER;
                            else begin
                                rd_reg     <= rd_reg - RS_DW'(1);
                                r.redirect = 1'b1;
                                r.target   = rsq_reg;
                            end
                        end
                        OP_SETP, OP_CLRP: begin
                            if (arg_idx_bad) r.fault = FAULT_INDEX;
                            else if (rval >= 32'(PIXEL_COUNT)) r.fault = FAULT_INDEX;
                            else begin
                                px_mem[rval[PIX_AW-1:0]] <= (op == OP_SETP);
                                gr_reg[ridx] <= '0;
                            end
                        end
                        default: ;
                    endcase
                    res_reg   <= r;
                    state_reg <= nxt;
                end
                ST_DIV: begin
                    if (drsp.done) begin
                        tos_reg   <= drsp.quotient;
                        dd_reg    <= dd_reg - DS_DW'(1);
                        res_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/sme_divider.sv
module sme_divider
    import sme_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  sme_div_req_t req,
    output sme_div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], quo_reg[31]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            quo_next  = req.dividend[31] ? 32'd0 - req.dividend : req.dividend;
            dsr_next  = req.divisor[31] ? 32'd0 - req.divisor : req.divisor;
            rem_next  = '0;
            neg_next  = req.dividend[31] ^ req.divisor[31];
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg) quo_next = 32'd0 - quo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import sme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class exec_scoreboard;
        logic [31:0] dstack[DATA_STACK_DEPTH];
        int          ddepth;
        logic [15:0] rstack[RETURN_STACK_DEPTH];
        int          rdepth;
        logic [31:0] regs[REG_COUNT];
        bit          pixels[PIXEL_COUNT];
        sme_out_t    pending[$];
        int          errors;

        function new();
            ddepth = 0;
            rdepth = 0;
            errors = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (pixels[i]) pixels[i] = 1'b0;
        endfunction

        function automatic bit taken(logic [4:0] op, logic signed [31:0] t,
                                     logic signed [31:0] n);
            case (op)
                OP_JB:   return t > n;
                OP_JBE:  return t >= n;
                OP_JA:   return t < n;
                OP_JAE:  return t <= n;
                OP_JE:   return t == n;
                default: return t != n;
            endcase
        endfunction

        function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_request(sme_in_t req);
            sme_out_t    r;
            logic [31:0] arg;
            logic [31:0] t;
            logic [31:0] n;
            logic [31:0] addr;
            r = '0;
            arg = req.argument;
            case (req.opcode)
                OP_PUSH, OP_PUSHR: begin
                    if (req.opcode == OP_PUSHR && arg >= REG_COUNT) r.fault = FAULT_INDEX;
                    else if (ddepth >= DATA_STACK_DEPTH) r.fault = FAULT_OVER;
                    else begin
                        dstack[ddepth] = (req.opcode == OP_PUSHR) ? regs[arg] : arg;
                        ddepth++;
                    end
                end
                OP_OUT: begin
                    if (ddepth < 1) r.fault = FAULT_UNDER;
                    else begin
                        ddepth--;
                        r.print_valid = 1'b1;
                        r.print_value = dstack[ddepth];
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (ddepth < 2) r.fault = FAULT_UNDER;
                    else begin
                        t = dstack[ddepth-1];
                        n = dstack[ddepth-2];
                        if (req.opcode == OP_DIV && n == 0) r.fault = FAULT_DIVZ;
                        else begin
                            case (req.opcode)
                                OP_ADD:  dstack[ddepth-2] = t + n;
                                OP_SUB:  dstack[ddepth-2] = t - n;
                                OP_MUL:  dstack[ddepth-2] = t * n;
                                default: dstack[ddepth-2] = quotient(t, n);
                            endcase
                            ddepth--;
                        end
                    end
                end
                OP_POPR: begin
                    if (arg >= REG_COUNT) r.fault = FAULT_INDEX;
                    else if (ddepth < 1) r.fault = FAULT_UNDER;
                    else begin
                        ddepth--;
                        regs[arg] = dstack[ddepth];
                    end
                end
                OP_JMP: begin
                    if (arg > 32'hFFFF) r.fault = FAULT_INDEX;
                    else begin
                        r.redirect = 1'b1;
                        r.target = arg[15:0];
                    end
                end
                OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
                    if (arg > 32'hFFFF) r.fault = FAULT_INDEX;
                    else if (ddepth < 2) r.fault = FAULT_UNDER;
                    else begin
                        t = dstack[ddepth-1];
                        n = dstack[ddepth-2];
                        ddepth -= 2;
                        if (taken(req.opcode, t, n)) begin
                            r.redirect = 1'b1;
                            r.target = arg[15:0];
                        end
                    end
                end
                OP_CALL: begin
                    if (arg > 32'hFFFF) r.fault = FAULT_INDEX;
                    else if (rdepth >= RETURN_STACK_DEPTH) r.fault = FAULT_OVER;
                    else begin
                        rstack[rdepth] = req.arg_position;
                        rdepth++;
                        r.redirect = 1'b1;
                        r.target = arg[15:0];
                    end
                end
                OP_RET: begin
                    if (rdepth < 1) r.fault = FAULT_UNDER;
                    else begin
                        rdepth--;
                        r.redirect = 1'b1;
                        r.target = rstack[rdepth];
                    end
                end
                OP_SETP, OP_CLRP: begin
                    if (arg >= REG_COUNT) r.fault = FAULT_INDEX;
                    else begin
                        addr = regs[arg];
                        if (addr >= PIXEL_COUNT) r.fault = FAULT_INDEX;
                        else begin
                            pixels[addr] = (req.opcode == OP_SETP);
                            regs[arg] = '0;
                        end
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(sme_out_t act);
            sme_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %p", act);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.print_valid !== e.print_valid) begin
                $error("print_valid exp %0d got %0d", e.print_valid, act.print_valid);
                errors++;
            end
            if (act.print_value !== e.print_value) begin
                $error("print_value exp %0d got %0d", e.print_value, act.print_value);
                errors++;
            end
            if (act.redirect !== e.redirect) begin
                $error("redirect exp %0d got %0d", e.redirect, act.redirect);
                errors++;
            end
            if (act.target !== e.target) begin
                $error("target exp %0d got %0d", e.target, act.target);
                errors++;
            end
            if (act.fault !== e.fault) begin
                $error("fault exp %0d got %0d", e.fault, act.fault);
                errors++;
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    sme_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    sme_out_t m_data;

    exec_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;

    stack_machine_execute_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // receiver readiness, redrawn every cycle unless held off
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send(logic [4:0] op, logic [31:0] arg, logic [15:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{opcode: op, argument: arg, arg_position: pos};
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(8) - 4;
            3: return $urandom_range(PIXEL_COUNT + 2);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_index();
        case ($urandom_range(9))
            0: return $urandom;
            1: return REG_COUNT;
            default: return $urandom_range(REG_COUNT - 1);
        endcase
    endfunction

    function automatic logic [31:0] rand_target();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'h0001_0000;
            2: return 32'h0000_FFFF;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    // one random instruction, biased to keep the data stack in its working range
    task automatic random_request();
        logic [4:0]  op;
        logic [31:0] arg;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 2) op = 5'(19 + $urandom_range(12));
        else if (sb.ddepth < 3 && pick < 50) op = OP_PUSH;
        else if (sb.ddepth > DATA_STACK_DEPTH - 3 && pick < 50) op = OP_OUT;
        else op = 5'($urandom_range(OP_CLRP));
        case (op)
            OP_PUSHR, OP_POPR, OP_SETP, OP_CLRP: arg = rand_index();
            OP_JMP, OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE, OP_CALL:
                arg = rand_target();
            default: arg = rand_value();
        endcase
        send(op, arg, 16'($urandom));
    endtask

    initial begin
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: faults on empty machine, then each operation but jb, jbe, ja, jae and jne, and edges
        send(OP_OUT, 0, 0);
        send(OP_ADD, 0, 0);
        send(OP_RET, 0, 0);
        send(OP_POPR, 0, 0);
        send(OP_POPR, REG_COUNT, 0);
        send(OP_PUSHR, 32'hFFFF_FFFF, 0);
        send(OP_JMP, 32'h0001_0000, 0);
        send(OP_JMP, 32'hFFFF, 0);
        send(OP_PUSH, 0, 0);
        send(OP_PUSH, 32'h7FFF_FFFF, 0);
        send(OP_DIV, 0, 0);
        send(OP_PUSH, 32'hFFFF_FFFF, 0);
        send(OP_PUSH, 32'h8000_0000, 0);
        send(OP_DIV, 0, 0);
        send(OP_OUT, 0, 0);
        send(OP_MUL, 0, 0);
        send(OP_SUB, 0, 0);
        send(OP_CALL, 32'h1234, 16'hFFFF);
        send(OP_RET, 0, 0);
        send(OP_PUSH, 5, 0);
        send(OP_PUSH, 5, 0);
        send(OP_JE, 32'h00AB, 0);
        send(OP_SETP, 3, 0);
        send(OP_PUSHR, 3, 0);
        send(OP_CLRP, 0, 0);
        drain();

        send_idle_pct = 32;
        recv_idle_pct = 63;
        repeat (500) random_request();

        // long receiver stall while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (20) random_request();
        join
        drain();

        send_idle_pct = 63;
        recv_idle_pct = 32;
        repeat (500) random_request();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (500) random_request();
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
